/* sv/chs_pkg.sv */
// ----------------------------------------------------------------------------
// chs_pkg: shared types, constants and microcode for the coalesced hash table
// Holds the table geometry, the control word layout and the step program.
// ----------------------------------------------------------------------------
package chs_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int KEY_WIDTH   = 31;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int SCAN_W      = $clog2(TABLE_DEPTH + 1);

  // port field widths
  localparam int KEY_IN_W   = 31;
  localparam int HOME_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int OUT_SLOT_W = 4;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_STORED   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // sequencer steps
  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_HOME,
    STEP_CMP,
    STEP_WALK,
    STEP_SCAN,
    STEP_PROBE,
    STEP_LINK
  } step_t;

  // branch conditions tested by a step
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_START,
    COND_HOME_FREE,
    COND_KEY_HIT,
    COND_CHAIN_END,
    COND_SCAN_EMPTY,
    COND_SCAN_FREE
  } cond_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_HOME_STORE,
    OP_FOUND,
    OP_FOLLOW,
    OP_SCAN_DEC,
    OP_OVERFLOW,
    OP_LINK
  } op_t;

  // ram address source
  typedef enum logic [1:0] {
    ASEL_POS,
    ASEL_LINK,
    ASEL_SCAN
  } asel_t;

  // one control word of the program
  typedef struct packed {
    cond_t cond;
    op_t   op_hit;
    step_t tgt_hit;
    op_t   op_miss;
    step_t tgt_miss;
    asel_t kasel;
    asel_t nasel;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    op_t   op;
    asel_t kasel;
    asel_t nasel;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic home_free;
    logic key_hit;
    logic chain_end;
    logic scan_empty;
    logic scan_free;
  } flags_t;

  // datapath result towards the output register
  typedef struct packed {
    logic                  valid;
    status_t               status;
    logic [OUT_SLOT_W-1:0] slot;
  } res_t;

  // program rom
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      STEP_IDLE:  w = '{cond: COND_START, op_hit: OP_LOAD, tgt_hit: STEP_HOME,
                        op_miss: OP_NOP, tgt_miss: STEP_IDLE,
                        kasel: ASEL_POS, nasel: ASEL_POS};
      STEP_HOME:  w = '{cond: COND_HOME_FREE, op_hit: OP_HOME_STORE, tgt_hit: STEP_IDLE,
                        op_miss: OP_NOP, tgt_miss: STEP_CMP,
                        kasel: ASEL_POS, nasel: ASEL_POS};
      STEP_CMP:   w = '{cond: COND_KEY_HIT, op_hit: OP_FOUND, tgt_hit: STEP_IDLE,
                        op_miss: OP_NOP, tgt_miss: STEP_WALK,
                        kasel: ASEL_POS, nasel: ASEL_POS};
      STEP_WALK:  w = '{cond: COND_CHAIN_END, op_hit: OP_NOP, tgt_hit: STEP_SCAN,
                        op_miss: OP_FOLLOW, tgt_miss: STEP_CMP,
                        kasel: ASEL_LINK, nasel: ASEL_LINK};
      STEP_SCAN:  w = '{cond: COND_SCAN_EMPTY, op_hit: OP_OVERFLOW, tgt_hit: STEP_IDLE,
                        op_miss: OP_NOP, tgt_miss: STEP_PROBE,
                        kasel: ASEL_POS, nasel: ASEL_POS};
      STEP_PROBE: w = '{cond: COND_SCAN_FREE, op_hit: OP_SCAN_DEC, tgt_hit: STEP_LINK,
                        op_miss: OP_SCAN_DEC, tgt_miss: STEP_SCAN,
                        kasel: ASEL_POS, nasel: ASEL_POS};
      STEP_LINK:  w = '{cond: COND_ALWAYS, op_hit: OP_LINK, tgt_hit: STEP_IDLE,
                        op_miss: OP_NOP, tgt_miss: STEP_IDLE,
                        kasel: ASEL_SCAN, nasel: ASEL_POS};
      default:    w = '{cond: COND_ALWAYS, op_hit: OP_NOP, tgt_hit: STEP_IDLE,
                        op_miss: OP_NOP, tgt_miss: STEP_IDLE,
                        kasel: ASEL_POS, nasel: ASEL_POS};
    endcase
    return w;
  endfunction

  // home slot reduced into the table range by repeated subtraction
  function automatic logic [SLOT_W-1:0] home_reduce(input logic [HOME_W-1:0] h);
    logic [HOME_W:0] v;
    v = {1'b0, h};
    for (int i = 0; i < 8; i++) begin
      if (int'(v) >= TABLE_DEPTH) begin
        v = v - (HOME_W+1)'(TABLE_DEPTH);
      end
    end
    return SLOT_W'(v);
  endfunction

endpackage

/* sv/chs_ram.sv */
// ----------------------------------------------------------------------------
// chs_ram: generic single-port ram
// One address for write and read, read data registered (old data on write).
// ----------------------------------------------------------------------------
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

/* sv/chs_sequencer.sv */
// ----------------------------------------------------------------------------
// chs_sequencer: microcode step counter
// Reads one control word per step, tests its condition and branches.
// ----------------------------------------------------------------------------
module chs_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  chs_pkg::flags_t flags,
  output chs_pkg::ctrl_t  ctrl,
  output logic            busy
);

  chs_pkg::step_t  step_r, step_nxt;
  chs_pkg::uword_t uw;
  logic            hit;

  // control word fetch and condition test
  always_comb begin
    uw = chs_pkg::ucode(step_r);
    case (uw.cond)
      chs_pkg::COND_ALWAYS:     hit = 1'b1;
      chs_pkg::COND_START:      hit = start;
      chs_pkg::COND_HOME_FREE:  hit = flags.home_free;
      chs_pkg::COND_KEY_HIT:    hit = flags.key_hit;
      chs_pkg::COND_CHAIN_END:  hit = flags.chain_end;
      chs_pkg::COND_SCAN_EMPTY: hit = flags.scan_empty;
      chs_pkg::COND_SCAN_FREE:  hit = flags.scan_free;
      default:                  hit = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    step_nxt = hit ? uw.tgt_hit : uw.tgt_miss;
  end

  // control outputs
  always_comb begin
    ctrl.op    = hit ? uw.op_hit : uw.op_miss;
    ctrl.kasel = uw.kasel;
    ctrl.nasel = uw.nasel;
    busy       = (step_r != chs_pkg::STEP_IDLE);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= chs_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* sv/chs_datapath.sv */
// ----------------------------------------------------------------------------
// chs_datapath: table storage and working registers
// Occupied and link marks in flops, keys and links in rams, free pointer.
// ----------------------------------------------------------------------------
module chs_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  chs_pkg::ctrl_t                 ctrl,
  input  logic [chs_pkg::KEY_IN_W-1:0]   in_key,
  input  logic [chs_pkg::HOME_W-1:0]     in_home_slot,
  output chs_pkg::flags_t                flags,
  output chs_pkg::res_t                  res
);

  localparam int DEPTH = chs_pkg::TABLE_DEPTH;
  localparam int SW    = chs_pkg::SLOT_W;
  localparam int CW    = chs_pkg::SCAN_W;
  localparam int KW    = chs_pkg::KEY_WIDTH;

  logic [KW-1:0]    key_r, key_nxt;
  logic [SW-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]    steps_r, steps_nxt;
  logic [CW-1:0]    free_scan_r, free_scan_nxt;
  logic [DEPTH-1:0] used_r, used_nxt;
  logic [DEPTH-1:0] link_r, link_nxt;

  logic [CW-1:0]    scan_m1;
  logic [SW-1:0]    free_idx;
  logic [SW-1:0]    kaddr, naddr;
  logic             kwe, nwe;
  logic [KW-1:0]    krd;
  logic [SW-1:0]    nrd;

  assign scan_m1  = free_scan_r - CW'(1);
  assign free_idx = free_scan_r[SW-1:0];

  // key and link stores
  chs_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_key_ram (
    .clk   (clk),
    .addr  (kaddr),
    .we    (kwe),
    .wdata (key_r),
    .rdata (krd)
  );

  chs_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_next_ram (
    .clk   (clk),
    .addr  (naddr),
    .we    (nwe),
    .wdata (free_idx),
    .rdata (nrd)
  );

  // ram address selection
  always_comb begin
    case (ctrl.kasel)
      chs_pkg::ASEL_POS:  kaddr = pos_r;
      chs_pkg::ASEL_LINK: kaddr = nrd;
      chs_pkg::ASEL_SCAN: kaddr = free_idx;
      default:            kaddr = pos_r;
    endcase
    case (ctrl.nasel)
      chs_pkg::ASEL_POS:  naddr = pos_r;
      chs_pkg::ASEL_LINK: naddr = nrd;
      chs_pkg::ASEL_SCAN: naddr = free_idx;
      default:            naddr = pos_r;
    endcase
  end

  // condition flags for the sequencer
  always_comb begin
    flags.home_free  = !used_r[pos_r];
    flags.key_hit    = (krd == key_r);
    flags.chain_end  = !link_r[pos_r] || (steps_r >= CW'(DEPTH));
    flags.scan_empty = (free_scan_r == '0);
    flags.scan_free  = !used_r[scan_m1[SW-1:0]];
  end

  // operation decode
  always_comb begin
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    steps_nxt     = steps_r;
    free_scan_nxt = free_scan_r;
    used_nxt      = used_r;
    link_nxt      = link_r;
    kwe           = 1'b0;
    nwe           = 1'b0;
    res.valid     = 1'b0;
    res.status    = chs_pkg::ST_FOUND;
    res.slot      = '0;
    case (ctrl.op)
      chs_pkg::OP_NOP: begin
      end
      chs_pkg::OP_LOAD: begin
        key_nxt   = KW'(in_key);
        pos_nxt   = chs_pkg::home_reduce(in_home_slot);
        steps_nxt = '0;
      end
      chs_pkg::OP_HOME_STORE: begin
        used_nxt[pos_r] = 1'b1;
        kwe             = 1'b1;
        res.valid       = 1'b1;
        res.status      = chs_pkg::ST_STORED;
        res.slot        = chs_pkg::OUT_SLOT_W'(pos_r);
      end
      chs_pkg::OP_FOUND: begin
        res.valid  = 1'b1;
        res.status = chs_pkg::ST_FOUND;
        res.slot   = chs_pkg::OUT_SLOT_W'(pos_r);
      end
      chs_pkg::OP_FOLLOW: begin
        pos_nxt   = nrd;
        steps_nxt = steps_r + CW'(1);
      end
      chs_pkg::OP_SCAN_DEC: begin
        free_scan_nxt = scan_m1;
      end
      chs_pkg::OP_OVERFLOW: begin
        res.valid  = 1'b1;
        res.status = chs_pkg::ST_OVERFLOW;
        res.slot   = '0;
      end
      chs_pkg::OP_LINK: begin
        link_nxt[pos_r]    = 1'b1;
        nwe                = 1'b1;
        used_nxt[free_idx] = 1'b1;
        kwe                = 1'b1;
        res.valid          = 1'b1;
        res.status         = chs_pkg::ST_STORED;
        res.slot           = chs_pkg::OUT_SLOT_W'(free_idx);
      end
      default: begin
      end
    endcase
  end

  // table marks and free pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      link_r      <= '0;
      free_scan_r <= CW'(DEPTH);
    end else begin
      used_r      <= used_nxt;
      link_r      <= link_nxt;
      free_scan_r <= free_scan_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    pos_r   <= pos_nxt;
    steps_r <= steps_nxt;
  end

endmodule

/* sv/coalesced_hash_search_insert.sv */
// ----------------------------------------------------------------------------
// coalesced_hash_search_insert: coalesced chained hash table, search/insert
// Microcoded sequencer over a small table of keys and chain links.
// ----------------------------------------------------------------------------
// Usage
//   A request is taken at a rising edge with start high and busy low; it
//   carries in_key and in_home_slot. The block looks the key up on the chain
//   from its home slot and stores it if absent. Exactly one result follows:
//   out_valid is high for one cycle with out_status (found, stored or
//   overflow) and out_slot; the receiver cannot stall and needs no handshake.
// Sequence
//   From idle a request goes to the home step, which stores the key when
//   the home slot is free; else a compare step checks the slot and, on a
//   miss, a walk step follows the chain link back to a compare step. At the
//   end of a chain the scan and probe steps move the free pointer down to
//   an empty slot and the link step stores the key there, or overflow is
//   reported. busy is low again in the strobe cycle, so the next request
//   can be taken there; one request is in flight at a time.
// Reset
//   Synchronous active-low rst_n clears occupied and link marks, sets the
//   free pointer to the top of the table and returns the sequencer to idle.
//   Stored keys and links need no clearing.
// ----------------------------------------------------------------------------
module coalesced_hash_search_insert (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [chs_pkg::KEY_IN_W-1:0]     in_key,
  input  logic [chs_pkg::HOME_W-1:0]       in_home_slot,
  output logic                             out_valid,
  output logic [chs_pkg::STATUS_W-1:0]     out_status,
  output logic [chs_pkg::OUT_SLOT_W-1:0]   out_slot
);

  chs_pkg::ctrl_t  ctrl;
  chs_pkg::flags_t flags;
  chs_pkg::res_t   res;

  logic                           out_valid_r;
  logic [chs_pkg::STATUS_W-1:0]   out_status_r;
  logic [chs_pkg::OUT_SLOT_W-1:0] out_slot_r;

  // step counter and program
  chs_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // table and working registers
  chs_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .in_key       (in_key),
    .in_home_slot (in_home_slot),
    .flags        (flags),
    .res          (res)
  );

  // result strobe register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_status_r <= res.status;
      out_slot_r   <= res.slot;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for coalesced_hash_search_insert
// A directed table fills the hash table through home slots and chains up to
// overflow, then random requests search for stored keys and probe fresh
// ones. Results are checked against typed plan rows or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_ITEMS   = 625;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4 * chs_pkg::TABLE_DEPTH + 16;

  // one expected result
  typedef struct {
    chs_pkg::status_t                st;
    logic [chs_pkg::OUT_SLOT_W-1:0]  slot;
  } answer_t;

  // one row of the directed plan
  typedef struct {
    logic [chs_pkg::KEY_IN_W-1:0]    key;
    logic [chs_pkg::HOME_W-1:0]      home;
    bit                              typed;
    chs_pkg::status_t                st;
    logic [chs_pkg::OUT_SLOT_W-1:0]  slot;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [chs_pkg::KEY_IN_W-1:0]    in_key = '0;
  logic [chs_pkg::HOME_W-1:0]      in_home_slot = '0;
  logic                            out_valid;
  logic [chs_pkg::STATUS_W-1:0]    out_status;
  logic [chs_pkg::OUT_SLOT_W-1:0]  out_slot;

  // predictor copy of the table
  bit                              used_mark [chs_pkg::TABLE_DEPTH];
  logic [chs_pkg::KEY_WIDTH-1:0]   key_store [chs_pkg::TABLE_DEPTH];
  bit                              link_mark [chs_pkg::TABLE_DEPTH];
  int                              link_to   [chs_pkg::TABLE_DEPTH];
  int                              free_ptr = chs_pkg::TABLE_DEPTH;

  answer_t                         pending [$];
  logic [chs_pkg::KEY_IN_W-1:0]    stored_keys [$];
  logic [chs_pkg::HOME_W-1:0]      stored_homes [$];
  int                              err_count = 0;
  int                              quiet_cycles = 0;

  coalesced_hash_search_insert u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_key       (in_key),
    .in_home_slot (in_home_slot),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_slot     (out_slot)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // search the chain from the home slot, store the key if it is absent
  task automatic lookup_insert(input logic [chs_pkg::KEY_IN_W-1:0] k,
                               input logic [chs_pkg::HOME_W-1:0] h,
                               output chs_pkg::status_t st,
                               output logic [chs_pkg::OUT_SLOT_W-1:0] slot);
    int pos;
    int hops;
    int r;
    bit hit;
    bit walking;
    bit got;
    pos = int'(h) % chs_pkg::TABLE_DEPTH;
    if (!used_mark[pos]) begin
      used_mark[pos] = 1'b1;
      key_store[pos] = k;
      stored_keys.push_back(k);
      stored_homes.push_back(h);
      st = chs_pkg::ST_STORED;
      slot = chs_pkg::OUT_SLOT_W'(pos);
      return;
    end
    // chain walk, bounded by the table depth
    hit = 1'b0;
    walking = 1'b1;
    hops = 0;
    while (walking) begin
      if (key_store[pos] == k) begin
        hit = 1'b1;
        walking = 1'b0;
      end else if (!link_mark[pos] || hops >= chs_pkg::TABLE_DEPTH) begin
        walking = 1'b0;
      end else begin
        pos = link_to[pos] % chs_pkg::TABLE_DEPTH;
        hops++;
      end
    end
    if (hit) begin
      st = chs_pkg::ST_FOUND;
      slot = chs_pkg::OUT_SLOT_W'(pos);
      return;
    end
    // free pointer moves down to the next empty slot
    r = (free_ptr > chs_pkg::TABLE_DEPTH) ? chs_pkg::TABLE_DEPTH : free_ptr;
    got = 1'b0;
    while (r > 0 && !got) begin
      r--;
      if (!used_mark[r]) got = 1'b1;
    end
    free_ptr = r;
    if (!got) begin
      st = chs_pkg::ST_OVERFLOW;
      slot = '0;
      return;
    end
    link_mark[pos] = 1'b1;
    link_to[pos] = r;
    used_mark[r] = 1'b1;
    key_store[r] = k;
    stored_keys.push_back(k);
    stored_homes.push_back(h);
    st = chs_pkg::ST_STORED;
    slot = chs_pkg::OUT_SLOT_W'(r);
  endtask

  // present one request and hold it until taken
  task automatic send_request(input logic [chs_pkg::KEY_IN_W-1:0] k,
                              input logic [chs_pkg::HOME_W-1:0] h,
                              input bit typed, input chs_pkg::status_t t_st,
                              input logic [chs_pkg::OUT_SLOT_W-1:0] t_slot);
    answer_t guess;
    in_key <= k;
    in_home_slot <= h;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    lookup_insert(k, h, guess.st, guess.slot);
    if (typed) begin
      guess.st = t_st;
      guess.slot = t_slot;
    end
    pending.push_back(guess);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // result checker
  answer_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending, status", int'(out_status), -1);
      end else begin
        want = pending.pop_front();
        if (out_status !== want.st)
          report_mismatch("status", int'(out_status), int'(want.st));
        if (out_slot !== want.slot)
          report_mismatch("slot", int'(out_slot), int'(want.slot));
      end
    end
  end

  // watchdog on cycles with no request taken and no result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("coalesced_hash_search_insert regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    plan_row_t                     plan [0:24];
    logic [chs_pkg::KEY_IN_W-1:0]  k;
    logic [chs_pkg::HOME_W-1:0]    h;
    int                            n;
    int                            j;

    // fill through home slots and coalesced chains, then overflow
    plan = '{
      '{31'h0000_0000, 4'd0,  1'b1, chs_pkg::ST_STORED,   4'd0},   // empty table after reset
      '{31'h7fff_ffff, 4'd15, 1'b1, chs_pkg::ST_STORED,   4'd15},  // largest key, top slot
      '{31'h0000_0000, 4'd0,  1'b1, chs_pkg::ST_FOUND,    4'd0},
      '{31'h7fff_ffff, 4'd15, 1'b1, chs_pkg::ST_FOUND,    4'd15},
      '{31'h0000_0001, 4'd0,  1'b0, chs_pkg::ST_FOUND,    4'd0},   // collision, chained store
      '{31'h0000_0001, 4'd0,  1'b0, chs_pkg::ST_FOUND,    4'd0},   // found one link down
      '{31'h0000_0002, 4'd15, 1'b0, chs_pkg::ST_FOUND,    4'd0},
      '{31'h4000_0000, 4'd0,  1'b0, chs_pkg::ST_FOUND,    4'd0},
      '{31'h2aaa_aaaa, 4'd5,  1'b1, chs_pkg::ST_STORED,   4'd5},
      '{31'h5555_5555, 4'd10, 1'b1, chs_pkg::ST_STORED,   4'd10},
      '{31'h0000_0003, 4'd12, 1'b0, chs_pkg::ST_FOUND,    4'd0},   // home taken by another chain
      '{31'h4000_0000, 4'd12, 1'b0, chs_pkg::ST_FOUND,    4'd0},
      '{31'h0000_0004, 4'd0,  1'b0, chs_pkg::ST_FOUND,    4'd0},   // walks the coalesced chain
      '{31'h0000_0004, 4'd0,  1'b0, chs_pkg::ST_FOUND,    4'd0},
      '{31'h0000_0005, 4'd5,  1'b0, chs_pkg::ST_FOUND,    4'd0},
      '{31'h0000_0006, 4'd5,  1'b0, chs_pkg::ST_FOUND,    4'd0},
      '{31'h0000_0007, 4'd5,  1'b0, chs_pkg::ST_FOUND,    4'd0},
      '{31'h0000_0008, 4'd5,  1'b0, chs_pkg::ST_FOUND,    4'd0},
      '{31'h0000_0009, 4'd5,  1'b0, chs_pkg::ST_FOUND,    4'd0},
      '{31'h0000_000a, 4'd5,  1'b0, chs_pkg::ST_FOUND,    4'd0},
      '{31'h0000_000b, 4'd5,  1'b0, chs_pkg::ST_FOUND,    4'd0},   // last free slot
      '{31'h0000_000c, 4'd5,  1'b1, chs_pkg::ST_OVERFLOW, 4'd0},   // table full
      '{31'h0000_000d, 4'd3,  1'b1, chs_pkg::ST_OVERFLOW, 4'd0},   // overflow again
      '{31'h0000_0008, 4'd5,  1'b0, chs_pkg::ST_FOUND,    4'd0},   // deep chain hit
      '{31'h7fff_fffe, 4'd9,  1'b0, chs_pkg::ST_FOUND,    4'd0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    for (n = 0; n < 25; n++) begin
      send_request(plan[n].key, plan[n].home, plan[n].typed, plan[n].st, plan[n].slot);
    end
    drain_results();

    // random part: mostly stored keys on their chains, the rest fresh keys
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) begin
        drain_results();
      end else if ((n < 120 || n >= 280) && $urandom_range(0, 99) < 12) begin
        hold_off($urandom_range(1, 6));
      end
      if (stored_keys.size() != 0 && $urandom_range(0, 99) < 60) begin
        j = $urandom_range(0, stored_keys.size() - 1);
        k = stored_keys[j];
        h = stored_homes[j];
        if ($urandom_range(0, 9) == 0) h = chs_pkg::HOME_W'($urandom_range(0, 15));
      end else begin
        k = chs_pkg::KEY_IN_W'($urandom);
        h = chs_pkg::HOME_W'($urandom_range(0, 15));
      end
      send_request(k, h, 1'b0, chs_pkg::ST_FOUND, '0);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pending.size() == 0) begin
      $display("coalesced_hash_search_insert regression: pass");
    end else begin
      $display("coalesced_hash_search_insert regression: fail");
    end
    $finish;
  end

endmodule
